/* src/ternary_weight_dot_product_core_defines.svh */
// Assertion macros shared by the ternary weight dot product design.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef TERNARY_WEIGHT_DOT_PRODUCT_CORE_DEFINES_SVH
`define TERNARY_WEIGHT_DOT_PRODUCT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define TWDP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define TWDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TWDP_ASSERT_SAME(lbl, ante, cons)

`define TWDP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/twdp_pkg.sv */
`timescale 1ns / 1ps

package twdp_pkg;

    localparam int LANES       = 4;
    localparam int CODE_W      = 2;
    localparam int ACT_W       = 8;
    localparam int WEIGHT_W    = LANES * CODE_W;
    // Four terms of magnitude up to 128 need two bits of growth plus sign.
    localparam int PART_W      = ACT_W + 3;
    localparam int SUM_W       = 32;
    localparam int IDX_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CODE_W-1:0] CODE_PLUS  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_MINUS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

    typedef struct packed {
        logic signed [PART_W-1:0] part;
        logic                     end_of_column;
    } t_item;

    function automatic logic signed [PART_W-1:0] lane_term(
        input logic [CODE_W-1:0]       code,
        input logic signed [ACT_W-1:0] act
    );
        logic signed [PART_W-1:0] wide;
        wide = PART_W'(act);
        unique case (code)
            CODE_PLUS:  lane_term = wide;
            CODE_MINUS: lane_term = -wide;
            default:    lane_term = '0;
        endcase
    endfunction

endpackage

/* src/twdp_front.sv */
`timescale 1ns / 1ps

module twdp_front (
    input  logic                                   i_in_valid,
    input  logic [twdp_pkg::WEIGHT_W-1:0]          i_weight_byte,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_0,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_1,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_2,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_3,
    input  logic                                   i_end_of_column,
    input  logic                                   i_q_full,
    output logic                                   o_in_ready,
    output logic                                   o_push,
    output twdp_pkg::t_item                        o_item
);

    logic signed [twdp_pkg::ACT_W-1:0]  acts  [twdp_pkg::LANES];
    logic signed [twdp_pkg::PART_W-1:0] terms [twdp_pkg::LANES];

    assign acts[0] = i_act_0;
    assign acts[1] = i_act_1;
    assign acts[2] = i_act_2;
    assign acts[3] = i_act_3;

    // Each lane decodes its own two-bit code into plus, minus or nothing.
    always_comb begin
        for (int lane = 0; lane < twdp_pkg::LANES; lane++) begin
            terms[lane] = twdp_pkg::lane_term(
                i_weight_byte[lane*twdp_pkg::CODE_W +: twdp_pkg::CODE_W], acts[lane]);
        end
    end

    assign o_in_ready         = !i_q_full;
    assign o_push             = i_in_valid && !i_q_full;
    assign o_item.part        = (terms[0] + terms[1]) + (terms[2] + terms[3]);
    assign o_item.end_of_column = i_end_of_column;

endmodule

/* src/twdp_queue.sv */
`timescale 1ns / 1ps
`include "ternary_weight_dot_product_core_defines.svh"

module twdp_queue #(
    parameter int DEPTH = twdp_pkg::QUEUE_DEPTH,
    parameter int WIDTH = $bits(twdp_pkg::t_item)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `TWDP_ASSERT_SAME(a_no_overflow, i_push, !o_full)
    `TWDP_ASSERT_SAME(a_no_underflow, i_pop, o_valid)
    `TWDP_ASSERT_NEXT(a_count_grows, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `TWDP_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))

endmodule

/* src/twdp_back.sv */
`timescale 1ns / 1ps
`include "ternary_weight_dot_product_core_defines.svh"

module twdp_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [twdp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [twdp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_q_valid,
    input  twdp_pkg::t_item                        i_item,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [twdp_pkg::SUM_W-1:0]      o_dot_sum,
    output logic [twdp_pkg::IDX_W-1:0]             o_row_index,
    output logic [twdp_pkg::IDX_W-1:0]             o_column_index,
    output logic                                   o_matrix_done
);

    logic [twdp_pkg::CFG_DATA_W-1:0] r_columns_per_row;
    logic [twdp_pkg::CFG_DATA_W-1:0] r_row_count;

    logic signed [twdp_pkg::SUM_W-1:0] r_sum;
    logic signed [twdp_pkg::SUM_W-1:0] n_sum;
    logic [twdp_pkg::IDX_W-1:0]        r_col;
    logic [twdp_pkg::IDX_W-1:0]        r_row;

    logic r_out_valid;
    logic signed [twdp_pkg::SUM_W-1:0] r_out_sum;
    logic [twdp_pkg::IDX_W-1:0]        r_out_row;
    logic [twdp_pkg::IDX_W-1:0]        r_out_col;
    logic                              r_out_done;

    logic out_free;
    logic emit;
    logic last_col;
    logic last_row;

    // A result can be loaded when the output register is empty or draining.
    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_q_valid && (!i_item.end_of_column || out_free);
    assign emit     = o_pop && i_item.end_of_column;

    assign n_sum    = r_sum + twdp_pkg::SUM_W'(i_item.part);
    assign last_col = ({1'b0, r_col} + 1'b1) >= {1'b0, r_columns_per_row};
    assign last_row = ({1'b0, r_row} + 1'b1) >= {1'b0, r_row_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns_per_row <= twdp_pkg::CFG_DATA_W'(1);
            r_row_count       <= twdp_pkg::CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                twdp_pkg::REG_COLUMNS: r_columns_per_row <= i_cfg_data;
                twdp_pkg::REG_ROWS:    r_row_count       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_sum       <= '0;
                r_out_valid <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                if (o_pop) begin
                    r_sum <= n_sum;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_sum  <= n_sum;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_done <= last_col && last_row;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dot_sum      = r_out_sum;
    assign o_row_index    = r_out_row;
    assign o_column_index = r_out_col;
    assign o_matrix_done  = r_out_done;

    `TWDP_ASSERT_NEXT(a_sum_cleared, emit, r_sum == '0)
    `TWDP_ASSERT_NEXT(a_done_wraps, emit && last_col && last_row, r_col == '0 && r_row == '0)
    `TWDP_ASSERT_NEXT(a_result_kept, r_out_valid && !i_out_ready,
                      r_out_valid && $stable(r_out_sum) && $stable(r_out_col))

endmodule

/* src/ternary_weight_dot_product_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    weight byte, four activations, end mark
// result    out        o_out_valid / i_out_ready  dot sum, row, column, matrix done
// config    in         i_cfg_valid / o_cfg_ready  register index, write data
//
// One item is taken each cycle unless the queue is full. Configuration writes complete at
// once. Items pass through a queue slot; a result is registered when its end item pops.
// Synchronous active-low reset empties the queue, clears the sum and indices, and sets
// both counts to one. A stalled result stops the back end at an end mark; the queue then
// absorbs up to QUEUE_DEPTH items before input ready falls.
module ternary_weight_dot_product_core #(
    parameter int QUEUE_DEPTH = twdp_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [twdp_pkg::WEIGHT_W-1:0]          i_weight_byte,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_0,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_1,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_2,
    input  logic signed [twdp_pkg::ACT_W-1:0]      i_act_3,
    input  logic                                   i_end_of_column,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [twdp_pkg::SUM_W-1:0]      o_dot_sum,
    output logic [twdp_pkg::IDX_W-1:0]             o_row_index,
    output logic [twdp_pkg::IDX_W-1:0]             o_column_index,
    output logic                                   o_matrix_done,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [twdp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [twdp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    twdp_pkg::t_item push_item;
    twdp_pkg::t_item pop_item;

    assign o_cfg_ready = 1'b1;

    twdp_front u_front (
        .i_in_valid      (i_in_valid),
        .i_weight_byte   (i_weight_byte),
        .i_act_0         (i_act_0),
        .i_act_1         (i_act_1),
        .i_act_2         (i_act_2),
        .i_act_3         (i_act_3),
        .i_end_of_column (i_end_of_column),
        .i_q_full        (q_full),
        .o_in_ready      (o_in_ready),
        .o_push          (q_push),
        .o_item          (push_item)
    );

    twdp_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(twdp_pkg::t_item))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_item)
    );

    twdp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_item         (pop_item),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_dot_sum      (o_dot_sum),
        .o_row_index    (o_row_index),
        .o_column_index (o_column_index),
        .o_matrix_done  (o_matrix_done)
    );

endmodule
